>>> design/adc_trimmed_mean_average_defines.svh
// Assertion helpers for the trimmed-mean averager checker.
`ifndef ADC_TRIMMED_MEAN_AVERAGE_DEFINES_SVH
`define ADC_TRIMMED_MEAN_AVERAGE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define ATMA_ASSERT_IMPLY(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ATMA_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define ATMA_ASSERT_NEXT_ALWAYS(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

>>> design/atma_pkg.sv
`default_nettype none
package atma_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SUM_BITS    = SAMPLE_BITS + 8;
  localparam int SAMPLE_W    = 12;
  localparam int AVG_W       = 12;
  localparam int CV_W        = 9;
  localparam int CNT_W       = 8;
  localparam int DIV_W       = 8;
  localparam int CV_SCALE    = 320;
  localparam int MIN_RUN     = 3;
  localparam int RESET_COUNT = 20;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int STEP_W      = $clog2(SUM_BITS);

  // One finished run handed from the front to the divider.
  typedef struct packed {
    logic [SUM_BITS-1:0]    sum;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] lo;
    logic [DIV_W-1:0]       divisor;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

>>> design/atma_if.sv
`default_nettype none
interface atma_in_if;
  logic                          valid;
  logic                          ready;
  logic [atma_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface atma_out_if;
  logic                       valid;
  logic                       ready;
  logic [atma_pkg::AVG_W-1:0] average;
  logic [atma_pkg::CV_W-1:0]  centivolts;
  modport source (output valid, output average, output centivolts, input ready);
  modport sink   (input valid, input average, input centivolts, output ready);
endinterface

interface atma_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [atma_pkg::CNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/atma_front.sv
`default_nettype none
module atma_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  atma_in_if.sink                  in_ch,
  atma_cfg_if.sink                 cfg_ch,
  input  wire atma_pkg::q_status_t q_status,
  output logic                     push,
  output atma_pkg::run_t           push_data
);

  logic [atma_pkg::SUM_BITS-1:0]    sum_r;
  logic [atma_pkg::SAMPLE_BITS-1:0] hi_r;
  logic [atma_pkg::SAMPLE_BITS-1:0] lo_r;
  logic [atma_pkg::CNT_W-1:0]       taken_r;
  logic [atma_pkg::CNT_W-1:0]       count_r;

  logic [atma_pkg::SAMPLE_BITS-1:0] s;
  logic [atma_pkg::SUM_BITS-1:0]    sum_nxt;
  logic [atma_pkg::SAMPLE_BITS-1:0] hi_nxt;
  logic [atma_pkg::SAMPLE_BITS-1:0] lo_nxt;
  logic [atma_pkg::CNT_W-1:0]       taken_nxt;
  logic [atma_pkg::CNT_W-1:0]       run_len;
  logic                             first;
  logic                             run_end;
  logic                             accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_status.full;
  assign accept       = in_ch.valid && !q_status.full;

  always_comb begin
    s         = in_ch.sample[atma_pkg::SAMPLE_BITS-1:0];
    first     = (taken_r == '0);
    hi_nxt    = (first || (s > hi_r)) ? s : hi_r;
    lo_nxt    = (first || (s < lo_r)) ? s : lo_r;
    sum_nxt   = sum_r + atma_pkg::SUM_BITS'(s);
    taken_nxt = taken_r + 1'b1;
    run_len   = (count_r < atma_pkg::CNT_W'(atma_pkg::MIN_RUN)) ?
                atma_pkg::CNT_W'(atma_pkg::MIN_RUN) : count_r;
    // a wrapped count stands for 256 samples and ends the run as well
    run_end   = (taken_nxt >= run_len) || (taken_nxt == '0);
  end

  assign push              = accept && run_end;
  assign push_data.sum     = sum_nxt;
  assign push_data.hi      = hi_nxt;
  assign push_data.lo      = lo_nxt;
  assign push_data.divisor = taken_nxt - atma_pkg::DIV_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= atma_pkg::CNT_W'(atma_pkg::RESET_COUNT);
    end else if (cfg_ch.valid) begin
      count_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      hi_r    <= '0;
      lo_r    <= '1;
      taken_r <= '0;
    end else if (accept) begin
      if (run_end) begin
        sum_r   <= '0;
        hi_r    <= '0;
        lo_r    <= '1;
        taken_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        hi_r    <= hi_nxt;
        lo_r    <= lo_nxt;
        taken_r <= taken_nxt;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/atma_queue.sv
`default_nettype none
module atma_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire atma_pkg::run_t       push_data,
  input  wire logic                 pop,
  output atma_pkg::run_t            pop_data,
  output atma_pkg::q_status_t       status
);

  atma_pkg::run_t                 mem_r [atma_pkg::QDEPTH];
  logic [atma_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [atma_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [atma_pkg::QCNT_W-1:0]    cnt_r;
  logic [atma_pkg::QPTR_W-1:0]    wr_ptr_nxt;
  logic [atma_pkg::QPTR_W-1:0]    rd_ptr_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign status.full  = (cnt_r == atma_pkg::QCNT_W'(atma_pkg::QDEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == atma_pkg::QPTR_W'(atma_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == atma_pkg::QPTR_W'(atma_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/atma_back.sv
`default_nettype none
module atma_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire atma_pkg::q_status_t q_status,
  input  wire atma_pkg::run_t      pop_data,
  output logic                     pop,
  atma_out_if.source               out_ch
);

  localparam int SB  = atma_pkg::SAMPLE_BITS;
  localparam int SUW = atma_pkg::SUM_BITS;
  localparam int DW  = atma_pkg::DIV_W;
  localparam int PW  = atma_pkg::SAMPLE_BITS + atma_pkg::CV_W;

  atma_pkg::back_state_t state_r, state_nxt;

  logic [SUW-1:0]                 quo_r, quo_nxt;
  logic [DW-1:0]                  rem_r, rem_nxt;
  logic [DW-1:0]                  div_r, div_nxt;
  logic [atma_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                           out_valid_r;
  logic [atma_pkg::AVG_W-1:0]     out_avg_r, out_avg_nxt;
  logic [atma_pkg::CV_W-1:0]      out_cv_r, out_cv_nxt;

  logic [DW:0]                    trial;
  logic [DW:0]                    diff;
  logic                           fits;
  logic [SB-1:0]                  avg;
  logic [PW-1:0]                  scaled;
  logic                           out_load;

  assign out_load = (state_r == atma_pkg::BK_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      atma_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = atma_pkg::BK_DIV;
        end
      end
      atma_pkg::BK_DIV: begin
        if (step_r == '0) begin
          state_nxt = atma_pkg::BK_DONE;
        end
      end
      atma_pkg::BK_DONE: begin
        if (out_load) begin
          state_nxt = atma_pkg::BK_IDLE;
        end
      end
      default: state_nxt = atma_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    trial       = {rem_r, quo_r[SUW-1]};
    diff        = trial - {1'b0, div_r};
    fits        = (trial >= {1'b0, div_r});
    avg         = (quo_r[SUW-1:SB] != '0) ? '1 : quo_r[SB-1:0];
    scaled      = PW'(avg) * PW'(atma_pkg::CV_SCALE);
    out_avg_nxt = atma_pkg::AVG_W'(avg);
    out_cv_nxt  = scaled[PW-1:SB];
    pop         = 1'b0;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    div_nxt     = div_r;
    step_nxt    = step_r;
    case (state_r)
      atma_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop      = 1'b1;
          quo_nxt  = pop_data.sum - SUW'(pop_data.hi) - SUW'(pop_data.lo);
          rem_nxt  = '0;
          div_nxt  = pop_data.divisor;
          step_nxt = atma_pkg::STEP_W'(SUW - 1);
        end
      end
      atma_pkg::BK_DIV: begin
        rem_nxt  = fits ? diff[DW-1:0] : trial[DW-1:0];
        quo_nxt  = {quo_r[SUW-2:0], fits};
        step_nxt = step_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atma_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
    if (out_load) begin
      out_avg_r <= out_avg_nxt;
      out_cv_r  <= out_cv_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.average    = out_avg_r;
  assign out_ch.centivolts = out_cv_r;

endmodule
`default_nettype wire

>>> design/adc_trimmed_mean_average.sv
// Throughput: one sample per cycle while the run queue has room; the divider
//   produces one quotient bit per cycle over 20 bits, and the front keeps
//   taking samples of the next run while the divider works on an earlier one.
// Reset: synchronous, active-low rst_n clears the run, the queue and the
//   divider and sets the run length to 20.
`default_nettype none
module adc_trimmed_mean_average (
  input  wire logic  clk,
  input  wire logic  rst_n,
  atma_in_if.sink    in_ch,
  atma_out_if.source out_ch,
  atma_cfg_if.sink   cfg_ch
);

  // Front: take samples, track sum, largest and smallest, close a run and
  // hand it over. Stall input only when the run queue is full.
  // Back: subtract the extremes, divide by the samples taken less two with a
  // restoring divider, clamp, scale to centivolts and hold the result in the
  // output register until the sink takes the request.

  atma_pkg::q_status_t q_status;
  atma_pkg::run_t      push_data;
  atma_pkg::run_t      pop_data;
  logic                push;
  logic                pop;

  atma_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple the per-sample front from the multi-cycle divider.
  atma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  atma_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

>>> design/atma_checker.sv
`default_nettype none
`include "adc_trimmed_mean_average_defines.svh"
module atma_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [atma_pkg::AVG_W-1:0] average,
  input wire logic [atma_pkg::CV_W-1:0]  centivolts,
  input wire logic                       cfg_ready
);

  logic [31:0] cv_expect;

  assign cv_expect = (32'(average) * 32'(atma_pkg::CV_SCALE)) >> atma_pkg::SAMPLE_BITS;

  `ATMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(average) && $stable(centivolts), "stalled result changed")
  `ATMA_ASSERT_IMPLY(a_cv_match, out_valid, 32'(centivolts) == cv_expect, "centivolts disagrees with average")
  `ATMA_ASSERT_NEXT_ALWAYS(a_reset_quiet, !rst_n, !out_valid && cfg_ready, "output not idle after reset")

endmodule

bind adc_trimmed_mean_average atma_checker u_atma_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .average    (out_ch.average),
  .centivolts (out_ch.centivolts),
  .cfg_ready  (cfg_ch.ready)
);
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import atma_pkg::*;

  // Run limits. The slowest correct run is roughly 1100 requests, each after
  // its pause, plus a hold-off and a divide for every result.
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int SAMPLE_TARGET  = 1050;
  localparam int RESULT_TARGET  = 40;
  localparam int SHORTEST_RUN   = 3;
  localparam int LONGEST_RUN    = 255;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // Run-averaging predictor: mirrors the block's run state and length
  // setting, and holds the results still owed by the block.
  class trimmed_mean_tracker;
    typedef struct {
      logic [AVG_W-1:0] average;
      logic [CV_W-1:0]  centivolts;
    } run_result_t;

    logic [CNT_W-1:0]    run_length;
    logic [SUM_BITS-1:0] run_sum;
    logic [SAMPLE_W-1:0] run_hi;
    logic [SAMPLE_W-1:0] run_lo;
    logic [CNT_W-1:0]    run_taken;
    run_result_t         owed[$];
    int                  mismatches;
    int                  results_seen;

    function void clear_run();
      run_sum   = '0;
      run_hi    = '0;
      run_lo    = SAMPLE_MAX;
      run_taken = '0;
    endfunction

    function void reset_state();
      run_length   = CNT_W'(RESET_COUNT);
      mismatches   = 0;
      results_seen = 0;
      owed.delete();
      clear_run();
    endfunction

    function void note_length(logic [CNT_W-1:0] len);
      run_length = len;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      int unsigned eff_len;
      int unsigned taken;
      int unsigned kept;
      int unsigned avg;
      run_result_t r;
      if (run_taken == 0) begin
        run_hi = s;
        run_lo = s;
      end else begin
        if (s > run_hi) run_hi = s;
        if (s < run_lo) run_lo = s;
      end
      run_sum   = run_sum + SUM_BITS'(s);
      run_taken = run_taken + 1'b1;
      eff_len   = (run_length < SHORTEST_RUN) ? SHORTEST_RUN : run_length;
      if (run_taken != 0 && run_taken < eff_len) return;
      taken = (run_taken == 0) ? 256 : run_taken;
      kept  = 32'(run_sum) - 32'(run_hi) - 32'(run_lo);
      avg   = kept / (taken - 2);
      if (avg > SAMPLE_MAX) avg = SAMPLE_MAX;
      r.average    = avg[AVG_W-1:0];
      r.centivolts = CV_W'((avg * CV_SCALE) >> SAMPLE_BITS);
      owed.push_back(r);
      clear_run();
    endfunction

    function void check_result(logic [AVG_W-1:0] average, logic [CV_W-1:0] centivolts);
      run_result_t r;
      results_seen++;
      if (owed.size() == 0) begin
        $error("unexpected result: average %0d centivolts %0d", average, centivolts);
        mismatches++;
        return;
      end
      r = owed.pop_front();
      if (average !== r.average) begin
        $error("average: expected %0d, got %0d", r.average, average);
        mismatches++;
      end
      if (centivolts !== r.centivolts) begin
        $error("centivolts: expected %0d, got %0d", r.centivolts, centivolts);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  atma_in_if  in_ch();
  atma_out_if out_ch();
  atma_cfg_if cfg_ch();

  adc_trimmed_mean_average dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  trimmed_mean_tracker tracker;

  int          in_gap_max;     // longest pause before a sample request
  int          out_stall_max;  // longest hold-off before taking a result
  int          next_gap;       // pause drawn for the coming sample request
  bit          in_held;        // in_ch.valid left high for the next request
  int          samples_sent;
  int          cycle_count;
  int          sample_mode;
  int          sample_base;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Kill a hung run. The fail line is printed here as well as at the end.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adc_trimmed_mean_average verification failed");
      $finish;
    end
  end

  // Result side: draw a hold-off per result, then take the next request
  // and compare it with the oldest owed result.
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      tracker.check_result(out_ch.average, out_ch.centivolts);
    end
  end

  // Send one sample request. Keep valid high across back-to-back requests
  // so that it is never lowered and raised in the same step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (!in_held) repeat (next_gap) @(posedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_sample(s);
    samples_sent++;
    next_gap = $urandom_range(0, in_gap_max);
    if (next_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end else begin
      in_held = 1'b1;
    end
  endtask

  // Drop valid, wait out every owed result, then let the divider settle; a
  // half-filled run stays in the front and is not owed.
  task automatic drain();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Change the run length only when the block is idle.
  task automatic write_length(input logic [CNT_W-1:0] len);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.note_length(len);
    cfg_ch.valid <= 1'b0;
  endtask

  // Shape each run: full range, rail-hugging, a narrow band or a flat line.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case (sample_mode)
      0: v = $urandom_range(0, SAMPLE_MAX);
      1: v = $urandom_range(0, 1) ? SAMPLE_MAX - $urandom_range(0, 3) : $urandom_range(0, 3);
      2: begin
        v = sample_base + $urandom_range(0, 31) - 16;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      end
      default: v = sample_base;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      default: return 16;
    endcase
  endfunction

  initial begin
    int pick;
    int eff_len;
    int runs;
    int burst;
    logic [CNT_W-1:0] len;

    tracker = new;
    tracker.reset_state();
    in_gap_max    = 0;
    out_stall_max = 0;
    next_gap      = 0;
    in_held       = 1'b0;
    samples_sent  = 0;
    cycle_count   = 0;
    sample_mode   = 0;
    sample_base   = 0;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    out_ch.ready  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a zero length acts as the shortest run; rails and flat lines.
    write_length(0);
    send_sample(0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(0);
    send_sample(0);
    send_sample(0);

    // Length two also clamps up; alternate bit patterns.
    write_length(2);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'hFFF);

    // Shorten the run mid-way: three samples taken at length five, then
    // the first sample at length three closes the run with four samples.
    write_length(5);
    send_sample(10);
    send_sample(20);
    send_sample(30);
    write_length(3);
    send_sample(40);

    write_length(1);
    send_sample(1);
    send_sample(2);
    send_sample(4);

    // Random phases. Mostly short runs; the odd full-length run and odd
    // register value. Some phases leave a run half-filled so that the next
    // length write lands mid-run.
    while (samples_sent < SAMPLE_TARGET || tracker.results_seen < RESULT_TARGET) begin
      pick = $urandom_range(0, 15);
      case (pick)
        0:       len = CNT_W'(LONGEST_RUN);
        1:       len = CNT_W'($urandom_range(0, LONGEST_RUN));
        2:       len = CNT_W'($urandom_range(0, SHORTEST_RUN - 1));
        3:       len = CNT_W'(SHORTEST_RUN);
        default: len = CNT_W'($urandom_range(SHORTEST_RUN, 24));
      endcase
      eff_len = (len < SHORTEST_RUN) ? SHORTEST_RUN : len;
      runs    = (eff_len > 40) ? 1 : $urandom_range(1, 4);
      burst   = eff_len * runs;
      if ($urandom_range(0, 2) == 0) burst += $urandom_range(1, eff_len - 1);
      // Trim the last phase so the total stays near the target.
      if (samples_sent < SAMPLE_TARGET && burst > SAMPLE_TARGET - samples_sent) begin
        burst = SAMPLE_TARGET - samples_sent;
      end

      write_length(len);
      in_gap_max    = pick_idle();
      out_stall_max = pick_idle();
      sample_mode   = $urandom_range(0, 3);
      sample_base   = $urandom_range(0, SAMPLE_MAX);
      repeat (burst) send_sample(pick_sample());
    end

    drain();
    if (tracker.mismatches == 0 && tracker.owed.size() == 0) begin
      $display("adc_trimmed_mean_average verification clean");
    end else begin
      $display("adc_trimmed_mean_average verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/atma_pkg.sv
design/atma_if.sv
design/atma_front.sv
design/atma_queue.sv
design/atma_back.sv
design/adc_trimmed_mean_average.sv
design/atma_checker.sv
bench/tb_top.sv
